### src/bmma_pkg.sv
// ----------------------------------------------------------------------------
// bmma_pkg: shared types and constants of the block matrix multiply-accumulate
// Command codes, field widths and the product word that runs down the cells.
// ----------------------------------------------------------------------------
package bmma_pkg;

    localparam int CMD_W    = 2;
    localparam int IDXF_W   = 6;
    localparam int VAL_W    = 16;
    localparam int PROD_W   = 2 * VAL_W;
    localparam int C_W      = 48;
    localparam int SIDE_W   = 4;
    localparam int TAG_W    = 3;
    localparam int PADDR_W  = 1;
    localparam int PDATA_W  = 32;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 56;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACC   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

    localparam logic [PADDR_W-1:0] REG_BLOCK_SIZE = 1'd0;

    typedef struct packed {
        logic                     valid;
        logic [TAG_W-1:0]         tag;
        logic signed [PROD_W-1:0] prod;
    } t_prod;

endpackage

### src/bmma_cell.sv
// ----------------------------------------------------------------------------
// bmma_cell: one column cell of the dot-product chain
// Holds the running dot product of one C column for the current row, adds
// the products tagged with its column and hands every product word on.
// During write-back the sums shift one cell toward the head.
// ----------------------------------------------------------------------------
module bmma_cell #(
    parameter int IDX   = 0,
    parameter int ACC_W = 36
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  bmma_pkg::t_prod         i_prod,
    output bmma_pkg::t_prod         o_prod,
    input  logic                    i_shift,
    input  logic signed [ACC_W-1:0] i_acc_next,
    output logic signed [ACC_W-1:0] o_acc
);

    localparam logic [bmma_pkg::TAG_W-1:0] CELL_TAG = IDX[bmma_pkg::TAG_W-1:0];

    logic signed [ACC_W-1:0]            r_acc;
    logic                               r_valid;
    logic [bmma_pkg::TAG_W-1:0]         r_tag;
    logic signed [bmma_pkg::PROD_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_prod.valid;
            if (i_shift) begin
                r_acc <= i_acc_next;
            end else if (i_prod.valid && i_prod.tag == CELL_TAG) begin
                r_acc <= r_acc + {{(ACC_W-bmma_pkg::PROD_W){i_prod.prod[bmma_pkg::PROD_W-1]}},
                                  i_prod.prod};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag  <= i_prod.tag;
        r_data <= i_prod.prod;
    end

    assign o_prod = {r_valid, r_tag, r_data};
    assign o_acc  = r_acc;

endmodule

### src/block_matrix_multiply_accumulate.sv
// ----------------------------------------------------------------------------
// block_matrix_multiply_accumulate: local block step of Cannon's algorithm
// Stores A and B blocks, accumulates A*B into a saturating Q32.16 C block,
// clears C and streams C out in row-major order.
// ----------------------------------------------------------------------------
// Operation, with r the block side in use: a load or a clear acts on its
// word as it is accepted. An accumulate runs row by row; each row issues
// r*r multiplies through one shared 16x16 multiplier into a chain of
// MAX_BLOCK column cells, drains the chain and writes the r sums back into
// C; the A and B stores each have a single read port. A read-out reads the
// C store into a register, then into the output register, and issues the
// next read only once the previous word has moved on. Input is taken only
// while no command is in progress. After reset C reads as zero at once;
// there is no clearing pass.
// ----------------------------------------------------------------------------
module block_matrix_multiply_accumulate #(
    parameter int MAX_BLOCK = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // tdata: command[1:0], element_index[7:2], a_value[23:8], b_value[39:24]
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [bmma_pkg::IN_W-1:0]         i_s_axis_tdata,
    // tdata: c_value[47:0], c_index[53:48], zeros[55:54]
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [bmma_pkg::OUT_W-1:0]        o_m_axis_tdata,
    // tuser: saturated[0]
    output logic                              o_m_axis_tuser,
    output logic                              o_m_axis_tlast,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [bmma_pkg::PADDR_W-1:0]      i_paddr,
    input  logic [bmma_pkg::PDATA_W-1:0]      i_pwdata,
    output logic [bmma_pkg::PDATA_W-1:0]      o_prdata,
    output logic                              o_pready
);

    localparam int DEPTH  = MAX_BLOCK * MAX_BLOCK;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(MAX_BLOCK);
    localparam int ACC_W  = bmma_pkg::PROD_W + 1 + IDX_W;
    localparam int NN_W   = ADDR_W + 1;
    localparam int DRAIN  = MAX_BLOCK + 1;
    localparam int DCNT_W = $clog2(MAX_BLOCK + 2);
    localparam int SUM_W  = bmma_pkg::C_W + 1;
    localparam int SW     = bmma_pkg::SIDE_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAC   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_WB    = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;

    localparam logic signed [bmma_pkg::C_W-1:0] C_MAX = {1'b0, {(bmma_pkg::C_W-1){1'b1}}};
    localparam logic signed [bmma_pkg::C_W-1:0] C_MIN = {1'b1, {(bmma_pkg::C_W-1){1'b0}}};

    // input word fields
    logic [bmma_pkg::CMD_W-1:0]         w_cmd;
    logic [bmma_pkg::IDXF_W-1:0]        w_idx;
    logic signed [bmma_pkg::VAL_W-1:0]  w_a;
    logic signed [bmma_pkg::VAL_W-1:0]  w_b;
    assign w_cmd = i_s_axis_tdata[1:0];
    assign w_idx = i_s_axis_tdata[7:2];
    assign w_a   = i_s_axis_tdata[23:8];
    assign w_b   = i_s_axis_tdata[39:24];

    logic [2:0]        r_state;
    logic [SW-1:0]     r_bsize;
    logic [SW-1:0]     w_side;
    logic              w_accept;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        if (r_bsize == '0) begin
            w_side = SW'(1);
        end else if (r_bsize > SW'(MAX_BLOCK)) begin
            w_side = SW'(MAX_BLOCK);
        end else begin
            w_side = r_bsize;
        end
    end

    // configuration port
    assign o_pready = 1'b1;
    assign o_prdata = bmma_pkg::PDATA_W'(r_bsize);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bsize <= SW'(8);
        end else if (i_psel && i_penable && i_pwrite && o_pready &&
                     i_paddr == bmma_pkg::REG_BLOCK_SIZE) begin
            r_bsize <= i_pwdata[SW-1:0];
        end
    end

    // A and B stores
    logic signed [bmma_pkg::VAL_W-1:0] mem_a [DEPTH];
    logic signed [bmma_pkg::VAL_W-1:0] mem_b [DEPTH];
    logic signed [bmma_pkg::VAL_W-1:0] r_a_rd;
    logic signed [bmma_pkg::VAL_W-1:0] r_b_rd;
    logic [ADDR_W-1:0]                 w_a_addr;
    logic [ADDR_W-1:0]                 w_b_addr;
    logic                              w_load;

    assign w_load = w_accept && w_cmd == bmma_pkg::CMD_LOAD &&
                    {1'b0, w_idx} < 7'(DEPTH);

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            mem_a[w_idx[ADDR_W-1:0]] <= w_a;
            mem_b[w_idx[ADDR_W-1:0]] <= w_b;
        end
        r_a_rd <= mem_a[w_a_addr];
        r_b_rd <= mem_b[w_b_addr];
    end

    // sequencer counters
    logic [IDX_W-1:0]  r_i, r_k, r_j;
    logic [ADDR_W-1:0] r_abase, r_kbase;
    logic [DCNT_W-1:0] r_dcnt;
    logic              w_last_i, w_last_k, w_last_j;

    assign w_last_i = (SW'(r_i) == w_side - SW'(1));
    assign w_last_k = (SW'(r_k) == w_side - SW'(1));
    assign w_last_j = (SW'(r_j) == w_side - SW'(1));
    assign w_a_addr = r_abase + ADDR_W'(r_k);
    assign w_b_addr = r_kbase + ADDR_W'(r_j);

    // multiplier pipeline feeding the cell chain
    logic                              r_v1, r_v2;
    logic [bmma_pkg::TAG_W-1:0]        r_t1, r_t2;
    logic signed [bmma_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= (r_state == S_MAC);
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t1 <= bmma_pkg::TAG_W'(r_j);
        r_t2 <= r_t1;
        r_p  <= r_a_rd * r_b_rd;
    end

    bmma_pkg::t_prod         w_link [MAX_BLOCK+1];
    logic signed [ACC_W-1:0] w_acc  [MAX_BLOCK];
    logic                    w_shift;

    assign w_link[0].valid = r_v2;
    assign w_link[0].tag   = r_t2;
    assign w_link[0].prod  = r_p;
    assign w_shift         = (r_state == S_WB);

    for (genvar c = 0; c < MAX_BLOCK; c++) begin : g_cell
        logic signed [ACC_W-1:0] w_next;
        if (c == MAX_BLOCK - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_acc[c+1];
        end
        bmma_cell #(
            .IDX   (c),
            .ACC_W (ACC_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_prod     (w_link[c]),
            .o_prod     (w_link[c+1]),
            .i_shift    (w_shift),
            .i_acc_next (w_next),
            .o_acc      (w_acc[c])
        );
    end

    // C store with valid bits and saturation marks
    logic signed [bmma_pkg::C_W-1:0] mem_c [DEPTH];
    logic signed [bmma_pkg::C_W-1:0] r_c_rd;
    logic [DEPTH-1:0]                r_cvalid;
    logic [DEPTH-1:0]                r_sat;
    logic [ADDR_W-1:0]               w_c_raddr;
    logic                            w_c_ren;

    // write-back stage
    logic                            r_wb_v;
    logic [ADDR_W-1:0]               r_wb_addr;
    logic signed [ACC_W-1:0]         r_wb_dot;
    logic signed [bmma_pkg::C_W-1:0] w_cold;
    logic signed [SUM_W-1:0]         w_sum;
    logic signed [bmma_pkg::C_W-1:0] w_cnew;
    logic                            w_ovf;

    assign w_cold = r_cvalid[r_wb_addr] ? r_c_rd : '0;
    assign w_sum  = {w_cold[bmma_pkg::C_W-1], w_cold} +
                    {{(SUM_W-ACC_W){r_wb_dot[ACC_W-1]}}, r_wb_dot};
    assign w_ovf  = w_sum[SUM_W-1] != w_sum[SUM_W-2];
    assign w_cnew = !w_ovf ? w_sum[bmma_pkg::C_W-1:0] :
                    (w_sum[SUM_W-1] ? C_MIN : C_MAX);

    always_ff @(posedge i_clk) begin
        if (r_wb_v) begin
            mem_c[r_wb_addr] <= w_cnew;
        end
        if (w_c_ren) begin
            r_c_rd <= mem_c[w_c_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid <= '0;
            r_sat    <= '0;
        end else if (w_accept && w_cmd == bmma_pkg::CMD_CLEAR) begin
            r_cvalid <= '0;
            r_sat    <= '0;
        end else if (r_wb_v) begin
            r_cvalid[r_wb_addr] <= 1'b1;
            if (w_ovf) begin
                r_sat[r_wb_addr] <= 1'b1;
            end
        end
    end

    // read-out
    logic [ADDR_W-1:0] r_n;
    logic [NN_W-1:0]   r_nn;
    logic              r_iss_done;
    logic              r_s1;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              r_s1_last;
    logic              w_issue;
    logic              w_out_free;
    logic              w_n_last;

    logic              r_ov;
    logic              r_olast;
    logic              r_osat;
    logic signed [bmma_pkg::C_W-1:0] r_oval;
    logic [bmma_pkg::IDXF_W-1:0]     r_oidx;

    assign w_out_free = !r_ov || i_m_axis_tready;
    assign w_issue    = (r_state == S_READ) && !r_iss_done && !r_s1;
    assign w_n_last   = (NN_W'(r_n) + NN_W'(1) == r_nn);
    assign w_c_ren    = w_issue || (r_state == S_WB);
    assign w_c_raddr  = (r_state == S_WB) ? (r_abase + ADDR_W'(r_j)) : r_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wb_v     <= 1'b0;
            r_s1       <= 1'b0;
            r_ov       <= 1'b0;
            r_iss_done <= 1'b0;
            r_i        <= '0;
            r_k        <= '0;
            r_j        <= '0;
            r_abase    <= '0;
            r_kbase    <= '0;
            r_dcnt     <= '0;
            r_n        <= '0;
            r_nn       <= '0;
        end else begin
            r_wb_v <= (r_state == S_WB);
            case (r_state)
                S_IDLE: begin
                    if (w_accept && w_cmd == bmma_pkg::CMD_ACC) begin
                        r_i     <= '0;
                        r_k     <= '0;
                        r_j     <= '0;
                        r_abase <= '0;
                        r_kbase <= '0;
                        r_state <= S_MAC;
                    end else if (w_accept && w_cmd == bmma_pkg::CMD_READ) begin
                        r_n        <= '0;
                        r_nn       <= NN_W'(w_side * w_side);
                        r_iss_done <= 1'b0;
                        r_state    <= S_READ;
                    end
                end
                S_MAC: begin
                    if (w_last_j) begin
                        r_j <= '0;
                        if (w_last_k) begin
                            r_k     <= '0;
                            r_kbase <= '0;
                            r_dcnt  <= '0;
                            r_state <= S_DRAIN;
                        end else begin
                            r_k     <= r_k + IDX_W'(1);
                            r_kbase <= r_kbase + ADDR_W'(w_side);
                        end
                    end else begin
                        r_j <= r_j + IDX_W'(1);
                    end
                end
                S_DRAIN: begin
                    if (r_dcnt == DCNT_W'(DRAIN)) begin
                        r_state <= S_WB;
                    end else begin
                        r_dcnt <= r_dcnt + DCNT_W'(1);
                    end
                end
                S_WB: begin
                    if (w_last_j) begin
                        r_j <= '0;
                        if (w_last_i) begin
                            r_state <= S_DONE;
                        end else begin
                            r_i     <= r_i + IDX_W'(1);
                            r_abase <= r_abase + ADDR_W'(w_side);
                            r_state <= S_MAC;
                        end
                    end else begin
                        r_j <= r_j + IDX_W'(1);
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                S_READ: begin
                    if (w_issue) begin
                        r_s1 <= 1'b1;
                        if (w_n_last) begin
                            r_iss_done <= 1'b1;
                        end else begin
                            r_n <= r_n + ADDR_W'(1);
                        end
                    end else if (r_s1 && w_out_free) begin
                        r_s1 <= 1'b0;
                    end
                    if (r_s1 && w_out_free) begin
                        r_ov <= 1'b1;
                    end else if (i_m_axis_tready) begin
                        r_ov <= 1'b0;
                    end
                    // leave once the final word is taken
                    if (r_ov && r_olast && i_m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WB) begin
            r_wb_addr <= r_abase + ADDR_W'(r_j);
            r_wb_dot  <= w_acc[0];
        end
        if (w_issue) begin
            r_s1_addr <= r_n;
            r_s1_last <= w_n_last;
        end
        if (r_s1 && w_out_free) begin
            r_oval  <= r_cvalid[r_s1_addr] ? r_c_rd : '0;
            r_oidx  <= bmma_pkg::IDXF_W'(r_s1_addr);
            r_osat  <= r_sat[r_s1_addr];
            r_olast <= r_s1_last;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {2'b00, r_oidx, r_oval};
    assign o_m_axis_tuser  = r_osat;
    assign o_m_axis_tlast  = r_olast;

    // checks
    a_out_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> r_state == S_READ)
        else $error("output word outside read-out");

    a_wb_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_v |-> (r_state != S_READ && r_state != S_IDLE))
        else $error("C write-back overlaps a new command");

    a_tail_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_link[MAX_BLOCK].valid |-> (r_state == S_MAC || r_state == S_DRAIN))
        else $error("product still in chain at write-back");

    a_row_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC && $past(r_state) != S_MAC) |-> w_acc[0] == '0)
        else $error("head cell not cleared at row start");

endmodule
